// ----- rtl/ks_pkg.sv -----
// Shared types, field widths and codes for the k-subset enumerator.
package ks_pkg;

    localparam int DEF_MAX_K  = 16;
    localparam int DEF_MAX_N  = 256;

    localparam int K_W        = 5;
    localparam int N_W        = 9;
    localparam int ELEM_W     = 8;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_K_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_N_COUNT = 2'd1;

    typedef enum logic [1:0] {
        STATUS_ELEM    = 2'd0,
        STATUS_NONE    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic load;
        logic advance;
    } cell_cmd_t;

endpackage

// ----- rtl/ks_cell.sv -----
// One slot of the subset: holds its index, its upper limit and the carry/fill logic.
module ks_cell #(
    parameter int POS = 0,
    parameter int VW  = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ks_pkg::cell_cmd_t        cmd_i,
    input  logic [ks_pkg::K_W-1:0]   k_i,
    input  logic [ks_pkg::N_W-1:0]   n_i,
    input  logic [VW-1:0]            left_value_i,
    input  logic                     right_full_i,
    output logic                     full_o,
    output logic [VW-1:0]            value_o
);
    import ks_pkg::*;

    logic [VW-1:0] value_reg, value_next;
    logic [VW-1:0] limit_reg, limit_next;
    logic          en_reg, en_next;
    logic          fill_reg, fill_next;
    logic          at_max;
    logic          pivot;

    assign at_max  = (value_reg == limit_reg);
    // rightmost slot below its limit, with everything to its right saturated
    assign pivot   = en_reg && !at_max && right_full_i;
    assign full_o  = !en_reg || (at_max && right_full_i);
    assign value_o = value_reg;

    always_comb begin
        value_next = value_reg;
        limit_next = limit_reg;
        en_next    = en_reg;
        fill_next  = fill_reg;
        if (cmd_i.load) begin
            value_next = VW'(POS);
            limit_next = VW'(int'(n_i) - int'(k_i) + POS);
            en_next    = (int'(k_i) > POS);
            fill_next  = 1'b0;
        end else if (cmd_i.advance) begin
            if (pivot) begin
                value_next = value_reg + VW'(1);
            end
            fill_next = en_reg && at_max && right_full_i;
        end else if (fill_reg) begin
            // ripples left neighbour + 1 along the tail, settles one slot a cycle
            value_next = left_value_i + VW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= 1'b0;
            fill_reg <= 1'b0;
        end else begin
            en_reg   <= en_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        limit_reg <= limit_next;
    end

endmodule

// ----- rtl/ks_chain.sv -----
// Row of subset cells with the carry chain and the element read-out.
module ks_chain #(
    parameter int MAX_K = 16,
    parameter int VW    = 8,
    parameter int PW    = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ks_pkg::cell_cmd_t        cmd_i,
    input  logic [ks_pkg::K_W-1:0]   k_i,
    input  logic [ks_pkg::N_W-1:0]   n_i,
    input  logic [PW-1:0]            rd_pos_i,
    output logic [VW-1:0]            rd_value_o,
    output logic                     done_o
);
    import ks_pkg::*;

    logic [VW-1:0] values [MAX_K];
    logic [VW-1:0] lefts  [MAX_K];
    logic          full   [MAX_K+1];

    assign full[MAX_K] = 1'b1;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign lefts[g] = '0;
        end else begin : g_rest
            assign lefts[g] = values[g-1];
        end

        ks_cell #(
            .POS (g),
            .VW  (VW)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd_i        (cmd_i),
            .k_i          (k_i),
            .n_i          (n_i),
            .left_value_i (lefts[g]),
            .right_full_i (full[g+1]),
            .full_o       (full[g]),
            .value_o      (values[g])
        );
    end

    // every slot saturated: the subset now held is the last one
    assign done_o     = full[0];
    assign rd_value_o = values[rd_pos_i];

endmodule

// ----- rtl/k_subset_enumerator.sv -----
// Top level of the lexicographic k-subset enumerator.
//
// Usage:
//  - cfg_wr_en/cfg_index/cfg_wdata write k_count (index 0) and n_count
//    (index 1) while the block is idle; other indexes are ignored.
//  - Input requests (s_valid/s_ready, s_restart) ask for the next subset.
//    s_restart latches k and n and starts again from 0..k-1; a bad setting
//    (k or n zero, k > n, k > MAX_K, n > MAX_N) gives one result, status 2.
//  - Each subset leaves on the m_ channel as k results in ascending order,
//    m_last on the final one. With no subset loaded, or past the final
//    subset, a single status 1 result is given.
//  - Timing: a status result is registered at the accepting edge; the
//    first element of a subset is registered in the S_EMIT state that follows.
//  - Each subset request runs through the accept, k outputs through the
//    slot read-out and one advance on the cell row; no new request is
//    taken until it is idle again. A single-result request ends at accept.
//  - The advance finds the pivot through the carry chain of the cells and
//    refills the tail one slot per cycle, overlapped with the next output.
//  - m_ready low holds the output register; emission waits and no new
//    request is taken until the output register is free.
//  - Reset (aresetn low, synchronous) gives k = n = 1 and no subset loaded.
module k_subset_enumerator #(
    parameter int MAX_K = ks_pkg::DEF_MAX_K,
    parameter int MAX_N = ks_pkg::DEF_MAX_N
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ks_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ks_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ks_pkg::ELEM_W-1:0]       m_element_index,
    output logic [ks_pkg::POS_W-1:0]        m_position,
    output logic                            m_last,
    output logic [1:0]                      m_status
);
    import ks_pkg::*;

    // n_count is 9 bits, so element values never exceed 510
    localparam int N_EFF = (MAX_N < 511) ? MAX_N : 511;
    localparam int VW    = $clog2(N_EFF);
    localparam int PW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EMIT = 3'b010,
        S_ADV  = 3'b100
    } state_t;

    // configuration
    logic [K_W-1:0] k_reg;
    logic [N_W-1:0] n_reg;

    // control
    state_t         state_reg, state_next;
    logic           active_reg, active_next;
    logic [K_W-1:0] cur_k_reg, cur_k_next;
    logic [PW-1:0]  pos_reg, pos_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [ELEM_W-1:0] m_elem_reg, m_elem_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic              m_last_reg, m_last_next;
    status_t           m_status_reg, m_status_next;

    cell_cmd_t     cmd;
    logic [VW-1:0] rd_value;
    logic          done;
    logic          out_free;
    logic          accept;
    logic          cfg_bad;
    logic          last_elem;

    ks_chain #(
        .MAX_K (MAX_K),
        .VW    (VW),
        .PW    (PW)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_i      (cmd),
        .k_i        (k_reg),
        .n_i        (n_reg),
        .rd_pos_i   (pos_reg),
        .rd_value_o (rd_value),
        .done_o     (done)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_bad   = (k_reg == '0) || (n_reg == '0) || (N_W'(k_reg) > n_reg)
                       || (int'(k_reg) > MAX_K) || (int'(n_reg) > MAX_N);
    assign last_elem = (int'(pos_reg) + 1 == int'(cur_k_reg));

    always_comb begin
        state_next    = state_reg;
        active_next   = active_reg;
        cur_k_next    = cur_k_reg;
        pos_next      = pos_reg;
        cmd           = '0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_elem_next   = m_elem_reg;
        m_pos_next    = m_pos_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_restart && cfg_bad) begin
                        active_next   = 1'b0;
                        m_valid_next  = 1'b1;
                        m_elem_next   = '0;
                        m_pos_next    = '0;
                        m_last_next   = 1'b1;
                        m_status_next = STATUS_INVALID;
                    end else if (s_restart) begin
                        cmd.load    = 1'b1;
                        active_next = 1'b1;
                        cur_k_next  = k_reg;
                        pos_next    = '0;
                        state_next  = S_EMIT;
                    end else if (!active_reg) begin
                        m_valid_next  = 1'b1;
                        m_elem_next   = '0;
                        m_pos_next    = '0;
                        m_last_next   = 1'b1;
                        m_status_next = STATUS_NONE;
                    end else begin
                        pos_next   = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_elem_next   = ELEM_W'(rd_value);
                    m_pos_next    = POS_W'(pos_reg);
                    m_last_next   = last_elem;
                    m_status_next = STATUS_ELEM;
                    if (last_elem) begin
                        state_next = S_ADV;
                    end else begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end
            S_ADV: begin
                cmd.advance = 1'b1;
                if (done) begin
                    active_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_W'(1);
            n_reg <= N_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_K_COUNT: k_reg <= cfg_wdata[K_W-1:0];
                REG_N_COUNT: n_reg <= cfg_wdata[N_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= 1'b0;
            cur_k_reg   <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            cur_k_reg   <= cur_k_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_elem_reg   <= m_elem_next;
        m_pos_reg    <= m_pos_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_element_index = m_elem_reg;
    assign m_position      = m_pos_reg;
    assign m_last          = m_last_reg;
    assign m_status        = m_status_reg;

`ifndef ASSERT_OFF
    a_emit_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> active_reg)
        else $error("emitting without a loaded subset");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (int'(pos_reg) < int'(cur_k_reg)))
        else $error("slot pointer beyond k");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_ELEM)) |-> m_last)
        else $error("status result not marked last");

    a_adv_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADV) |=> (state_reg == S_IDLE))
        else $error("advance lasted more than one cycle");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the k-subset enumerator: directed table, then random walks.
module tb_top;
    import ks_pkg::*;

    // Predictor limits follow the block's default parameters
    localparam int SLOTS   = DEF_MAX_K;
    localparam int SET_MAX = DEF_MAX_N;

    // Spare register indexes: writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Cycles allowed after the last result for the tail refill of the cell row
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 190;
    localparam int CALM_ITEMS    = 30;   // final stretch with no random gaps or stalls
    localparam int HOLD_FROM     = 60;   // long receiver hold-off starts near here
    localparam int LONG_HOLD     = 80;
    localparam int PAUSE_AT      = 120;  // sender waits for every result mid-walk
    localparam int END_LIMIT     = 20000;
    localparam int LIMIT_TIME    = 1600000;

    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [POS_W-1:0]  pos;
        logic              last;
        status_t           status;
    } subset_beat_t;

    typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] wdata;
        logic                 restart;
        bit                   typed;     // expected result written into the row
        subset_beat_t         beat;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_restart = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ELEM_W-1:0]     m_element_index;
    logic [POS_W-1:0]      m_position;
    logic                  m_last;
    logic [1:0]            m_status;

    // Predictor state: register copies, the subset latched at restart, walk flag
    logic [K_W-1:0]    cfg_k = 5'd1;
    logic [N_W-1:0]    cfg_n = 9'd1;
    logic [K_W-1:0]    walk_k = '0;
    logic [N_W-1:0]    walk_n = '0;
    logic [ELEM_W-1:0] walk_slot [SLOTS];
    bit                walking = 1'b0;

    subset_beat_t beats_due [$];
    plan_row_t    plan [$];
    int           faults = 0;

    // Handshake between the sender and the receiver for the long hold-off
    bit hold_ask  = 1'b0;
    bit hold_done = 1'b0;
    bit calm      = 1'b0;
    bit gap_on    = 1'b1;

    k_subset_enumerator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_element_index (m_element_index),
        .m_position      (m_position),
        .m_last          (m_last),
        .m_status        (m_status)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("%0t: timed out with %0d results outstanding", $time, beats_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic subset_beat_t mk_beat(logic [ELEM_W-1:0] e, logic [POS_W-1:0] p,
                                             logic l, status_t s);
        subset_beat_t b;
        b.elem   = e;
        b.pos    = p;
        b.last   = l;
        b.status = s;
        return b;
    endfunction

    // Appends one awaited result at the tail of the queue
    function automatic void queue_beat(subset_beat_t b);
        beats_due = {beats_due, b};
    endfunction

    // Works out the results of one accepted request and steps the walk on.
    function automatic void enumerate_next(input logic restart);
        int s;
        int j;
        int p;
        bit moved;
        if (restart) begin
            // bad setting: one status result, walk dropped
            if (cfg_k == 0 || cfg_n == 0 || cfg_k > cfg_n || cfg_k > SLOTS
                    || cfg_n > SET_MAX) begin
                walking = 1'b0;
                queue_beat(mk_beat(8'd0, 4'd0, 1'b1, STATUS_INVALID));
                return;
            end
            walk_k = cfg_k;
            walk_n = cfg_n;
            for (p = 0; p < int'(walk_k); p++)
                walk_slot[p] = ELEM_W'(p);
            walking = 1'b1;
        end
        // not started, or the last subset has already gone out
        if (!walking) begin
            queue_beat(mk_beat(8'd0, 4'd0, 1'b1, STATUS_NONE));
            return;
        end
        for (p = 0; p < int'(walk_k); p++)
            queue_beat(mk_beat(walk_slot[p], POS_W'(p),
                               p == int'(walk_k) - 1, STATUS_ELEM));
        // pivot is the rightmost slot still below n - k + slot
        moved = 1'b0;
        for (s = int'(walk_k) - 1; s >= 0 && !moved; s--) begin
            if (int'(walk_slot[s]) < int'(walk_n) - int'(walk_k) + s) begin
                walk_slot[s] = walk_slot[s] + 8'd1;
                for (j = s + 1; j < int'(walk_k); j++)
                    walk_slot[j] = walk_slot[j-1] + 8'd1;
                moved = 1'b1;
            end
        end
        if (!moved)
            walking = 1'b0;
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.kind    = ROW_WRITE;
        row.idx     = idx;
        row.wdata   = data;
        row.restart = 1'b0;
        row.typed   = 1'b0;
        row.beat    = '0;
        plan = {plan, row};
    endfunction

    function automatic void add_request(logic rs, bit typed, subset_beat_t beat);
        plan_row_t row;
        row.kind    = ROW_REQUEST;
        row.idx     = '0;
        row.wdata   = '0;
        row.restart = rs;
        row.typed   = typed;
        row.beat    = beat;
        plan = {plan, row};
    endfunction

    // Register write; the predictor copy follows at the same edge.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_K_COUNT: cfg_k = data[K_W-1:0];
            REG_N_COUNT: cfg_n = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Drop valid, let every awaited result come back, then let the row settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Offers one request and predicts it at the edge where it is taken.
    // Valid is left high afterwards; the next call or a drain decides its fate.
    task automatic offer_request(input logic rs, input bit typed, input subset_beat_t typed_beat);
        int mark;
        if (!calm && gap_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= rs;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        mark = beats_due.size();
        enumerate_next(rs);
        // rows with a hand-written answer replace what the predictor produced
        if (typed) begin
            while (beats_due.size() > mark)
                void'(beats_due.pop_back());
            queue_beat(typed_beat);
        end
    endtask

    // Receiver: random stall bursts in stretches, one long hold-off on request
    initial begin : rx_side
        int span;
        bit stall_mode;
        span = 0;
        stall_mode = 1'b0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                stall_mode = ($urandom_range(0, 2) != 0);
                span = 40;
            end
            span--;
            if (hold_ask && !hold_done) begin
                // long hold: the output register fills and the input stalls behind it
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && stall_mode && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: each taken result against the oldest one awaited
    always @(posedge aclk) begin : result_check
        subset_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (beats_due.size() == 0) begin
                faults++;
                $display("%0t: expected nothing, got elem %0d pos %0d last %0d status %0d",
                         $time, m_element_index, m_position, m_last, m_status);
            end else begin
                want = beats_due.pop_front();
                if (m_element_index !== want.elem || m_position !== want.pos
                        || m_last !== want.last || m_status !== want.status) begin
                    faults++;
                    $display("%0t: expected e%0d p%0d l%0d s%0d, got e%0d p%0d l%0d s%0d",
                             $time, want.elem, want.pos, want.last, want.status,
                             m_element_index, m_position, m_last, m_status);
                end
            end
        end
    end

    initial begin : stimulus
        int rand_sent;
        int n_req;
        int i;
        int k_pick;
        int n_pick;
        int spin;
        logic rs;
        logic [CFG_DATA_W-1:0] kword;

        // Directed table: reset state, a short walk, every bad setting,
        // spare indexes, and the largest sizes
        add_request(1'b0, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_NONE));
        add_request(1'b1, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_ELEM));
        add_request(1'b0, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_NONE));
        add_write(REG_K_COUNT, 9'd3);
        add_write(REG_N_COUNT, 9'd5);
        add_request(1'b1, 1'b0, '0);
        repeat (4) add_request(1'b0, 1'b0, '0);
        // k above n written mid-walk: the walk carries on until restart
        add_write(REG_K_COUNT, 9'd6);
        add_request(1'b0, 1'b0, '0);
        add_request(1'b1, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_INVALID));
        add_request(1'b0, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_NONE));
        add_write(REG_K_COUNT, 9'd0);
        add_request(1'b1, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_INVALID));
        add_write(REG_K_COUNT, 9'd1);
        add_write(REG_N_COUNT, 9'd0);
        add_request(1'b1, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_INVALID));
        add_write(REG_K_COUNT, 9'd17);
        add_write(REG_N_COUNT, 9'd256);
        add_request(1'b1, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_INVALID));
        add_write(REG_K_COUNT, 9'd4);
        add_write(REG_N_COUNT, 9'd300);
        add_request(1'b1, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_INVALID));
        add_write(REG_N_COUNT, 9'd4);
        add_write(REG_SPARE_2, 9'h1FF);
        add_write(REG_SPARE_3, 9'h003);
        add_request(1'b1, 1'b0, '0);
        add_request(1'b0, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_NONE));
        add_write(REG_K_COUNT, 9'd16);
        add_write(REG_N_COUNT, 9'd256);
        add_request(1'b1, 1'b0, '0);
        add_request(1'b0, 1'b0, '0);
        add_write(REG_K_COUNT, 9'd1);
        add_request(1'b1, 1'b0, '0);
        add_request(1'b0, 1'b0, '0);
        add_write(REG_K_COUNT, 9'd16);
        add_write(REG_N_COUNT, 9'd16);
        add_request(1'b1, 1'b0, '0);
        add_request(1'b0, 1'b1, mk_beat(8'd0, 4'd0, 1'b1, STATUS_NONE));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                drain_results();
                reg_write(plan[r].idx, plan[r].wdata);
            end else begin
                offer_request(plan[r].restart, plan[r].typed, plan[r].beat);
            end
        end

        // Random walks: mostly short walks on small sets, some bad
        // settings, a few large ones
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 4))
                        0: begin k_pick = 0; n_pick = $urandom_range(1, 20); end
                        1: begin k_pick = $urandom_range(1, 16); n_pick = 0; end
                        2: begin
                            n_pick = $urandom_range(1, 15);
                            k_pick = $urandom_range(n_pick + 1, 16);
                        end
                        3: begin k_pick = $urandom_range(17, 31); n_pick = $urandom_range(17, 256); end
                        default: begin
                            k_pick = $urandom_range(1, 16);
                            n_pick = $urandom_range(257, 511);
                        end
                    endcase
                    n_req = $urandom_range(2, 4);
                end
                1: begin
                    if ($urandom_range(0, 2) == 0) begin
                        k_pick = 16;
                        n_pick = 256;
                    end else begin
                        k_pick = $urandom_range(1, 16);
                        n_pick = $urandom_range(200, 256);
                    end
                    n_req = $urandom_range(2, 5);
                end
                default: begin
                    n_pick = $urandom_range(1, 9);
                    k_pick = $urandom_range(1, n_pick);
                    n_req = $urandom_range(4, 18);
                end
            endcase
            if (!hold_ask && rand_sent >= HOLD_FROM) begin
                hold_ask = 1'b1;
                n_req = 12;
            end
            // the last group stops at the planned item count
            if (n_req > RANDOM_ITEMS - rand_sent)
                n_req = RANDOM_ITEMS - rand_sent;
            gap_on = ($urandom_range(0, 2) != 0);

            kword = CFG_DATA_W'(k_pick);
            if ($urandom_range(0, 3) == 0)
                kword[CFG_DATA_W-1:K_W] = 4'($urandom);   // upper bits do not belong to k
            if ($urandom_range(0, 1) == 0) begin
                reg_write(REG_K_COUNT, kword);
                reg_write(REG_N_COUNT, CFG_DATA_W'(n_pick));
            end else begin
                reg_write(REG_N_COUNT, CFG_DATA_W'(n_pick));
                reg_write(REG_K_COUNT, kword);
            end
            if ($urandom_range(0, 7) == 0)
                reg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom));

            for (i = 0; i < n_req; i++) begin
                if (i == 0)
                    rs = ($urandom_range(0, 9) != 0);
                else
                    rs = ($urandom_range(0, 7) == 0);
                offer_request(rs, 1'b0, '0);
                rand_sent++;
                calm = (RANDOM_ITEMS - rand_sent) <= CALM_ITEMS;
                if (rand_sent == PAUSE_AT)
                    drain_results();
            end
        end

        s_valid <= 1'b0;
        spin = 0;
        while (beats_due.size() != 0 && spin < END_LIMIT) begin
            @(posedge aclk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (beats_due.size() != 0) begin
            faults++;
            $display("%0t: %0d results never arrived, oldest elem %0d pos %0d status %0d",
                     $time, beats_due.size(), beats_due[0].elem, beats_due[0].pos,
                     beats_due[0].status);
        end
        if (faults == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
